FILE: rtl/hsvw_pkg.sv
// Shared constants, a side-data type and a helper function of the HSV to RGBW converter.
package hsvw_pkg;

    localparam int LVL_W   = 10;
    localparam int HUE_W   = 13;
    localparam int SHIFT_W = 10;
    localparam int TEMP_W  = 15;
    localparam int MODEL_W = 2;
    localparam int CIDX_W  = 3;
    localparam int PROD_W  = 2 * LVL_W;
    localparam int DVS_W   = 11;
    localparam int DVD_W   = 21;
    localparam int SEC_W   = 3;
    localparam int BD_W    = 15;

    localparam int LEVEL_MAX = 1023;
    localparam int HUE_SPAN  = 6138;
    localparam int SHIFT_LIM = LEVEL_MAX / 2;
    localparam int RB_SW     = HUE_SPAN / 8;
    localparam int RB_T1     = LEVEL_MAX / 3;
    localparam int RB_T2     = (LEVEL_MAX / 3) * 2;
    localparam int DIV_STEPS = LVL_W;

    // Model codes; the unused code behaves as raw.
    localparam logic [MODEL_W-1:0] MODEL_RAW      = 2'd0;
    localparam logic [MODEL_W-1:0] MODEL_SPECTRUM = 2'd1;
    localparam logic [MODEL_W-1:0] MODEL_RAINBOW  = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_HUE_MODEL = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RED       = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_YELLOW    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GREEN     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_CYAN      = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_BLUE      = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_MAGENTA   = 3'd6;

    // Data riding alongside the ratio divider
    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [LVL_W-1:0]  chroma;
        logic [LVL_W-1:0]  white;
        logic [TEMP_W-1:0] temp;
    } side_t;

    // x / LEVEL_MAX for x below LEVEL_MAX * (LEVEL_MAX + 1), one correction step
    function automatic logic [LVL_W-1:0] div_lmax(input logic [PROD_W-1:0] x);
        logic [LVL_W-1:0] q0;
        logic [LVL_W:0]   r;
        q0 = x[PROD_W-1:LVL_W];
        r  = {1'b0, x[LVL_W-1:0]} + {1'b0, q0};
        return (r >= (LVL_W+1)'(LEVEL_MAX)) ? q0 + 1'b1 : q0;
    endfunction

endpackage

FILE: rtl/hsvw_ratio_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module hsvw_ratio_div
    import hsvw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  in_dividend,
    input  logic [DVS_W-1:0]  in_divisor,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [LVL_W-1:0]  out_quotient,
    output logic [DVS_W-1:0]  out_remainder,
    output side_t             out_side
);

    logic              vld_reg [DIV_STEPS];
    logic [DVD_W-1:0]  rem_reg [DIV_STEPS];
    logic [LVL_W-1:0]  quo_reg [DIV_STEPS];
    logic [DVS_W-1:0]  dvs_reg [DIV_STEPS];
    side_t             side_reg[DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic              vld_in;
        logic [DVD_W-1:0]  rem_in;
        logic [LVL_W-1:0]  quo_in;
        logic [DVS_W-1:0]  dvs_in;
        side_t             side_in;
        logic [DVD_W-1:0]  trial;
        logic [DVD_W-1:0]  rem_next;
        logic [LVL_W-1:0]  quo_next;

        if (j == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_dividend;
            assign quo_in  = '0;
            assign dvs_in  = in_divisor;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign dvs_in  = dvs_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign trial = DVD_W'(dvs_in) << (DIV_STEPS - 1 - j);

        always_comb begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                quo_next[DIV_STEPS-1-j] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (adv) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                dvs_reg[j]  <= dvs_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid     = vld_reg[DIV_STEPS-1];
    assign out_quotient  = quo_reg[DIV_STEPS-1];
    assign out_remainder = rem_reg[DIV_STEPS-1][DVS_W-1:0];
    assign out_side      = side_reg[DIV_STEPS-1];

endmodule

FILE: rtl/hsv_to_rgbw_hue_wheel_unit.sv
// HSV to RGBW converter with a configurable six-sector or fixed rainbow hue wheel.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | hue, saturation, brightness, color_temp
//  m_      | out       | m_valid / m_ready    | red, green, blue, white levels, temp_out
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle when m_ready stays high. The pipe holds two front
// stages, ten divider stages for the sector position ratio, operand, multiply
// and output stages. Synchronous active-low reset empties the pipe and returns
// the configuration to the raw model with unshifted boundaries.
// A stall at the output holds every stage in place.
module hsv_to_rgbw_hue_wheel_unit
    import hsvw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [SHIFT_W-1:0]  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HUE_W-1:0]    s_hue,
    input  logic [LVL_W-1:0]    s_saturation,
    input  logic [LVL_W-1:0]    s_brightness,
    input  logic [TEMP_W-1:0]   s_color_temp,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LVL_W-1:0]    m_red_level,
    output logic [LVL_W-1:0]    m_green_level,
    output logic [LVL_W-1:0]    m_blue_level,
    output logic [LVL_W-1:0]    m_white_level,
    output logic [TEMP_W-1:0]   m_temp_out
);

    // configuration
    logic [MODEL_W-1:0]        model_reg;
    logic signed [SHIFT_W-1:0] shift_reg [6];
    logic signed [SHIFT_W-1:0] shift_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        shift_next = cfg_data;
        if (shift_next < -SHIFT_W'(SHIFT_LIM)) begin
            shift_next = -SHIFT_W'(SHIFT_LIM);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg <= MODEL_RAW;
            for (int k = 0; k < 6; k++) begin
                shift_reg[k] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HUE_MODEL: model_reg    <= cfg_data[MODEL_W-1:0];
                CFG_RED:       shift_reg[0] <= shift_next;
                CFG_YELLOW:    shift_reg[1] <= shift_next;
                CFG_GREEN:     shift_reg[2] <= shift_next;
                CFG_CYAN:      shift_reg[3] <= shift_next;
                CFG_BLUE:      shift_reg[4] <= shift_next;
                CFG_MAGENTA:   shift_reg[5] <= shift_next;
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    assign adv     = m_ready || !out_valid_reg;
    assign s_ready = adv;

    // stage 1: hue wrap, saturation times brightness
    logic              v1_reg;
    logic [HUE_W-1:0]  hue1_reg;
    logic [PROD_W-1:0] sv1_reg;
    logic [LVL_W-1:0]  val1_reg;
    logic [TEMP_W-1:0] ct1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hue1_reg <= (s_hue >= HUE_W'(HUE_SPAN)) ? s_hue - HUE_W'(HUE_SPAN) : s_hue;
            sv1_reg  <= PROD_W'(s_saturation) * PROD_W'(s_brightness);
            val1_reg <= s_brightness;
            ct1_reg  <= s_color_temp;
        end
    end

    // stage 2: chroma, sector search, offset and width
    logic signed [BD_W-1:0] bd [7];
    logic signed [BD_W-1:0] hue_s;
    logic signed [BD_W-1:0] off_s;
    logic signed [BD_W-1:0] wid_s;
    logic [3:0]             rb_sec;
    logic [HUE_W-1:0]       rb_h;
    logic [SEC_W-1:0]       sec_c;
    logic [DVS_W-1:0]       num_c;
    logic [DVS_W-1:0]       dvs_c;
    logic [LVL_W-1:0]       chroma_c;

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            bd[k] = BD_W'(k * LEVEL_MAX) + BD_W'(shift_reg[k % 6]);
        end
        hue_s    = $signed({2'b00, hue1_reg});
        chroma_c = div_lmax(sv1_reg);

        if (hue_s < bd[0] || (hue_s > bd[5] && hue_s <= bd[6])) begin
            sec_c = 3'd5;
            off_s = (hue_s < bd[0]) ? hue_s + BD_W'(HUE_SPAN) - bd[5] : hue_s - bd[5];
            wid_s = bd[6] - bd[5];
        end else if (hue_s <= bd[1] || hue_s > bd[6]) begin
            sec_c = 3'd0;
            off_s = (hue_s > bd[6]) ? hue_s - bd[6] : hue_s + BD_W'(HUE_SPAN) - bd[6];
            wid_s = bd[1] - bd[0];
        end else if (hue_s <= bd[2]) begin
            sec_c = 3'd1;
            off_s = hue_s - bd[1];
            wid_s = bd[2] - bd[1];
        end else if (hue_s <= bd[3]) begin
            sec_c = 3'd2;
            off_s = hue_s - bd[2];
            wid_s = bd[3] - bd[2];
        end else if (hue_s <= bd[4]) begin
            sec_c = 3'd3;
            off_s = hue_s - bd[3];
            wid_s = bd[4] - bd[3];
        end else begin
            sec_c = 3'd4;
            off_s = hue_s - bd[4];
            wid_s = bd[5] - bd[4];
        end
        num_c = off_s[DVS_W-1:0];
        dvs_c = wid_s[DVS_W-1:0];

        rb_sec = '0;
        for (int k = 1; k <= 8; k++) begin
            rb_sec = rb_sec + 4'(hue1_reg >= HUE_W'(k * RB_SW));
        end
        rb_h = hue1_reg - HUE_W'(rb_sec * RB_SW);

        if (model_reg == MODEL_RAINBOW) begin
            sec_c = (rb_sec > 4'd7) ? 3'd7 : rb_sec[SEC_W-1:0];
            num_c = rb_h[DVS_W-1:0];
            dvs_c = DVS_W'(RB_SW);
        end
    end

    logic              v2_reg;
    logic [DVS_W-1:0]  num2_reg;
    logic [DVS_W-1:0]  dvs2_reg;
    side_t             side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num2_reg         <= num_c;
            dvs2_reg         <= dvs_c;
            side2_reg.sector <= sec_c;
            side2_reg.chroma <= chroma_c;
            side2_reg.white  <= val1_reg - chroma_c;
            side2_reg.temp   <= ct1_reg;
        end
    end

    // ratio divider
    logic [DVD_W-1:0] dvd_c;
    logic             vd;
    logic [LVL_W-1:0] quo;
    logic [DVS_W-1:0] rem;
    side_t            side_d;

    assign dvd_c = (model_reg == MODEL_RAINBOW)
                 ? DVD_W'(num2_reg) * DVD_W'(RB_T1)
                 : (DVD_W'(num2_reg) << LVL_W) - DVD_W'(num2_reg);

    hsvw_ratio_div u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (v2_reg),
        .in_dividend   (dvd_c),
        .in_divisor    (dvs2_reg),
        .in_side       (side2_reg),
        .out_valid     (vd),
        .out_quotient  (quo),
        .out_remainder (rem),
        .out_side      (side_d)
    );

    // operand stage
    logic [LVL_W-1:0] p2;
    logic [LVL_W-1:0] a1_c;
    logic [LVL_W-1:0] m1_c;
    logic [LVL_W-1:0] m2_c;

    always_comb begin
        p2   = LVL_W'({quo, 1'b0}) + LVL_W'({rem, 1'b0} >= (DVS_W+1)'(RB_SW));
        a1_c = side_d.chroma;
        m1_c = quo;
        m2_c = LVL_W'(LEVEL_MAX) - quo;
        case (model_reg)
            MODEL_RAINBOW: begin
                case (side_d.sector)
                    3'd0: begin m1_c = LVL_W'(LEVEL_MAX) - quo; m2_c = quo; end
                    3'd1: begin m1_c = LVL_W'(RB_T2); m2_c = LVL_W'(RB_T1) + quo; end
                    3'd2: begin m1_c = LVL_W'(RB_T2) - p2; m2_c = LVL_W'(RB_T2) + quo; end
                    3'd3: begin m1_c = LVL_W'(LEVEL_MAX) - quo; m2_c = quo; end
                    3'd4: begin m1_c = LVL_W'(RB_T2) - p2; m2_c = LVL_W'(RB_T1) + p2; end
                    3'd5: begin m1_c = quo; m2_c = LVL_W'(LEVEL_MAX) - quo; end
                    3'd6: begin m1_c = LVL_W'(RB_T1) + quo; m2_c = LVL_W'(RB_T2) - quo; end
                    default: begin m1_c = LVL_W'(RB_T2) + quo; m2_c = LVL_W'(RB_T1) - quo; end
                endcase
            end
            MODEL_SPECTRUM: begin
                a1_c = side_d.chroma >> 1;
                m2_c = '0;
            end
            default: ;
        endcase
    end

    logic             v4_reg;
    logic [LVL_W-1:0] a14_reg;
    logic [LVL_W-1:0] m14_reg;
    logic [LVL_W-1:0] m24_reg;
    side_t            side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a14_reg   <= a1_c;
            m14_reg   <= m1_c;
            m24_reg   <= m2_c;
            side4_reg <= side_d;
        end
    end

    // multiply stage
    logic              v5_reg;
    logic [PROD_W-1:0] pr1_reg;
    logic [PROD_W-1:0] pr2_reg;
    side_t             side5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr1_reg   <= PROD_W'(a14_reg) * PROD_W'(m14_reg);
            pr2_reg   <= PROD_W'(side4_reg.chroma) * PROD_W'(m24_reg);
            side5_reg <= side4_reg;
        end
    end

    // scale back and route to the channels
    logic [LVL_W-1:0] y1;
    logic [LVL_W-1:0] y2;
    logic [LVL_W-1:0] c5;
    logic [LVL_W-1:0] h5;
    logic [LVL_W-1:0] r_c;
    logic [LVL_W-1:0] g_c;
    logic [LVL_W-1:0] b_c;

    always_comb begin
        y1  = div_lmax(pr1_reg);
        y2  = div_lmax(pr2_reg);
        c5  = side5_reg.chroma;
        h5  = c5 >> 1;
        r_c = '0;
        g_c = '0;
        b_c = '0;
        case (model_reg)
            MODEL_RAINBOW: begin
                case (side5_reg.sector)
                    3'd0, 3'd1, 3'd2: begin r_c = y1; g_c = y2; end
                    3'd3, 3'd4:       begin g_c = y1; b_c = y2; end
                    default:          begin r_c = y1; b_c = y2; end
                endcase
            end
            MODEL_SPECTRUM: begin
                case (side5_reg.sector)
                    3'd0: begin r_c = c5 - y1; g_c = y1; end
                    3'd1: begin r_c = h5 - y1; g_c = h5 + y1; end
                    3'd2: begin g_c = c5 - y1; b_c = y1; end
                    3'd3: begin g_c = h5 - y1; b_c = h5 + y1; end
                    3'd4: begin r_c = y1; b_c = c5 - y1; end
                    default: begin r_c = h5 + y1; b_c = h5 - y1; end
                endcase
            end
            default: begin
                case (side5_reg.sector)
                    3'd0: begin r_c = c5; g_c = y1; end
                    3'd1: begin r_c = y2; g_c = c5; end
                    3'd2: begin g_c = c5; b_c = y1; end
                    3'd3: begin g_c = y2; b_c = c5; end
                    3'd4: begin r_c = y1; b_c = c5; end
                    default: begin r_c = c5; b_c = y2; end
                endcase
            end
        endcase
    end

    logic [LVL_W-1:0]  red_reg;
    logic [LVL_W-1:0]  green_reg;
    logic [LVL_W-1:0]  blue_reg;
    logic [LVL_W-1:0]  white_reg;
    logic [TEMP_W-1:0] temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= r_c;
            green_reg <= g_c;
            blue_reg  <= b_c;
            white_reg <= side5_reg.white;
            temp_reg  <= side5_reg.temp;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;
    assign m_white_level = white_reg;
    assign m_temp_out    = temp_reg;

endmodule
